>>> rtl/core/box_average_3x3_stencil_top_defines.svh
// ----------------------------------------------------------------------------
// Box average 3x3 stencil - assertion macros
// Shared concurrent assertion helpers; compiled out under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BOX_AVERAGE_3X3_STENCIL_TOP_DEFINES_SVH
`define BOX_AVERAGE_3X3_STENCIL_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition must never hold
`define BAVG_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bavg: forbidden condition");

// same-cycle implication
`define BAVG_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bavg: implication failed");

// next-cycle implication
`define BAVG_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bavg: next-cycle implication failed");

`else

`define BAVG_NEVER(lbl, clk, rst_n, cond)
`define BAVG_IMPL(lbl, clk, rst_n, ante, cons)
`define BAVG_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/bavg_pkg.sv
// ----------------------------------------------------------------------------
// Box average 3x3 stencil - package
// Shared widths, constants, register codes and types.
// ----------------------------------------------------------------------------
package bavg_pkg;

  localparam int VALUE_W         = 16;
  localparam int CFG_W           = 11;
  localparam int CFG_IDX_W       = 1;

  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MIN_HEIGHT      = 3;
  localparam int MIN_COLUMNS     = 1;
  localparam int CFG_HEIGHT_RST  = 1024;
  localparam int CFG_COLUMNS_RST = 1024;

  // three cells across
  localparam int HSUM_W = VALUE_W + 2;
  // nine cells plus rounding, < 2^20
  localparam int SUM_W  = VALUE_W + 4;

  // x/9 == (x * ceil(2^24/9)) >> 24 for x < 2^21
  localparam int                 RECIP_W    = 21;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 21'd1864136;
  localparam int                 DIV9_SHIFT = 24;
  localparam int                 PROD_W     = SUM_W + RECIP_W;
  localparam logic [SUM_W-1:0]   ROUND_HALF = 20'd4;

  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_HEIGHT    = 1'b0,
    REG_INTERIOR_COLUMNS = 1'b1
  } cfg_reg_t;

  // work queued from front to back: one or two results
  typedef struct packed {
    logic [SUM_W-1:0]   a_raw;   // rounded nine-cell sum, or copied cell
    logic               is_copy;
    logic               two;     // bottom row also gives the last cell
    logic [VALUE_W-1:0] b_val;
    logic               last;
  } q_entry_t;

  typedef struct packed {
    logic emit;
    logic copy;
    logic two;
    logic last;
  } cls_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mid;  // previous column
    logic [VALUE_W-1:0] old;  // column before that
  } line_pair_t;

  function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    int unsigned r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

>>> rtl/core/bavg_if.sv
// ----------------------------------------------------------------------------
// Box average 3x3 stencil - stream interfaces
// Cell input channel and result output channel, valid/ready.
// ----------------------------------------------------------------------------
interface bavg_cell_if;
  logic                          valid;
  logic                          ready;
  logic [bavg_pkg::VALUE_W-1:0]  cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface bavg_result_if;
  logic                          valid;
  logic                          ready;
  logic [bavg_pkg::VALUE_W-1:0]  new_value;
  logic                          frame_done;

  modport source (output valid, output new_value, output frame_done, input ready);
  modport sink   (input valid, input new_value, input frame_done, output ready);
endinterface

>>> rtl/core/bavg_queue.sv
// ----------------------------------------------------------------------------
// Box average 3x3 stencil - work queue
// Small register FIFO between the front and the back end.
// ----------------------------------------------------------------------------
`include "box_average_3x3_stencil_top_defines.svh"

module bavg_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  bavg_pkg::q_entry_t                  push_data,
  input  logic                                pop,
  output bavg_pkg::q_entry_t                  head,
  output logic                                nonempty,
  output logic [bavg_pkg::QCNT_W-1:0]         level
);

  bavg_pkg::q_entry_t                  q_mem [bavg_pkg::Q_DEPTH];
  logic [bavg_pkg::QPTR_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [bavg_pkg::QCNT_W-1:0]         count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= push_data;
  end

  assign head     = q_mem[rd_ptr_r];
  assign nonempty = (count_r != '0);
  assign level    = count_r;

  `BAVG_NEVER(a_push_full, clk, rst_n, push && (count_r == bavg_pkg::QCNT_W'(bavg_pkg::Q_DEPTH)))
  `BAVG_NEXT(a_level_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

>>> rtl/core/bavg_front.sv
// ----------------------------------------------------------------------------
// Box average 3x3 stencil - front end
// Tracks row/column, keeps two line stores, forms the nine-cell sums and
// queues the result work for the back end.
// ----------------------------------------------------------------------------
`include "box_average_3x3_stencil_top_defines.svh"

module bavg_front #(
  parameter int MAX_HEIGHT  = bavg_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_COLUMNS = bavg_pkg::MAX_COLUMNS_DEF,
  localparam int ROW_W = $clog2(MAX_HEIGHT),
  localparam int COL_W = $clog2(MAX_COLUMNS + 2)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bavg_cell_if.sink                    in_ch,
  input  logic                         restart,
  input  logic [ROW_W-1:0]             height_last,
  input  logic [COL_W-1:0]             col_last,
  input  logic [bavg_pkg::QCNT_W-1:0]  q_level,
  output logic                         q_push,
  output bavg_pkg::q_entry_t           q_data
);

  logic                   in_fire;
  logic [ROW_W-1:0]       row_r;
  logic [COL_W-1:0]       col_r;
  bavg_pkg::cls_t         cls_nxt;

  logic                               s1_valid_r;
  logic [bavg_pkg::VALUE_W-1:0]       s1_cell_r;
  logic [ROW_W-1:0]                   s1_row_r;
  bavg_pkg::cls_t                     s1_cls_r;
  bavg_pkg::line_pair_t               rdata_r;

  bavg_pkg::line_pair_t               line_mem [MAX_HEIGHT];

  logic [bavg_pkg::HSUM_W-1:0]        hsum, hs1_r, hs2_r;
  logic [bavg_pkg::VALUE_W-1:0]       mid_prev_r;
  logic [bavg_pkg::SUM_W-1:0]         vsum4;

  // words in flight in stage 1 count against queue space
  assign in_ch.ready = (q_level + bavg_pkg::QCNT_W'(s1_valid_r))
                       < bavg_pkg::QCNT_W'(bavg_pkg::Q_DEPTH);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // classify the incoming cell
  always_comb begin
    cls_nxt.emit = (col_r >= COL_W'(2)) && (row_r != '0);
    cls_nxt.copy = (row_r == ROW_W'(1));
    cls_nxt.two  = cls_nxt.emit && (row_r == height_last);
    cls_nxt.last = cls_nxt.two && (col_r == col_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else if (restart) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      if (in_fire) begin
        if (row_r == height_last) begin
          row_r <= '0;
          if (col_r == col_last) col_r <= '0;
          else                   col_r <= col_r + 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cell_r <= in_ch.cell_value;
      s1_row_r  <= row_r;
      s1_cls_r  <= cls_nxt;
    end
  end

  // line stores: read on accept, shift the row one column along in the next cycle
  always_ff @(posedge clk) begin
    if (in_fire) rdata_r <= line_mem[row_r];
    if (s1_valid_r) line_mem[s1_row_r] <= '{mid: s1_cell_r, old: rdata_r.mid};
  end

  assign hsum = bavg_pkg::HSUM_W'(s1_cell_r) + bavg_pkg::HSUM_W'(rdata_r.mid)
              + bavg_pkg::HSUM_W'(rdata_r.old);

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      hs1_r      <= hsum;
      hs2_r      <= hs1_r;
      mid_prev_r <= rdata_r.mid;
    end
  end

  assign vsum4 = bavg_pkg::SUM_W'(hsum) + bavg_pkg::SUM_W'(hs1_r) + bavg_pkg::SUM_W'(hs2_r)
               + bavg_pkg::ROUND_HALF;

  assign q_push = s1_valid_r && s1_cls_r.emit;

  always_comb begin
    q_data.a_raw   = s1_cls_r.copy ? bavg_pkg::SUM_W'(mid_prev_r) : vsum4;
    q_data.is_copy = s1_cls_r.copy;
    q_data.two     = s1_cls_r.two;
    q_data.b_val   = rdata_r.mid;
    q_data.last    = s1_cls_r.last;
  end

  `BAVG_NEXT(a_fire_stage, clk, rst_n, in_fire && !restart, s1_valid_r)

endmodule

>>> rtl/core/bavg_back.sv
// ----------------------------------------------------------------------------
// Box average 3x3 stencil - back end
// Divides the rounded sum by nine, or passes a copied cell, and emits one
// or two result words per queue entry through a registered output.
// ----------------------------------------------------------------------------
`include "box_average_3x3_stencil_top_defines.svh"

module bavg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  bavg_pkg::q_entry_t  q_head,
  output logic                q_pop,
  bavg_result_if.source       out_ch
);

  logic                                m_valid_r, m_copy_r, m_two_r, m_last_r, phase_r;
  logic [bavg_pkg::PROD_W-1:0]         m_prod_r;
  logic [bavg_pkg::VALUE_W-1:0]        m_copy_val_r, m_b_r;
  logic                                o_valid_r, o_done_r;
  logic [bavg_pkg::VALUE_W-1:0]        o_value_r;
  logic [bavg_pkg::VALUE_W-1:0]        result_sel;
  logic                                o_load, m_release;

  assign o_load    = !o_valid_r || out_ch.ready;
  assign m_release = o_load && m_valid_r && (!m_two_r || phase_r);
  assign q_pop     = q_valid && (!m_valid_r || m_release);

  always_comb begin
    if (phase_r)       result_sel = m_b_r;
    else if (m_copy_r) result_sel = m_copy_val_r;
    else               result_sel = m_prod_r[bavg_pkg::DIV9_SHIFT +: bavg_pkg::VALUE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      phase_r   <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (q_pop)          m_valid_r <= 1'b1;
      else if (m_release) m_valid_r <= 1'b0;

      if (q_pop || m_release)                          phase_r <= 1'b0;
      else if (o_load && m_valid_r && m_two_r)         phase_r <= 1'b1;

      if (o_load) o_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_prod_r     <= bavg_pkg::PROD_W'(q_head.a_raw)
                      * bavg_pkg::PROD_W'(bavg_pkg::DIV9_RECIP);
      m_copy_val_r <= q_head.a_raw[bavg_pkg::VALUE_W-1:0];
      m_copy_r     <= q_head.is_copy;
      m_two_r      <= q_head.two;
      m_last_r     <= q_head.last;
      m_b_r        <= q_head.b_val;
    end
    if (o_load && m_valid_r) begin
      o_value_r <= result_sel;
      o_done_r  <= phase_r && m_last_r;
    end
  end

  assign out_ch.valid      = o_valid_r;
  assign out_ch.new_value  = o_value_r;
  assign out_ch.frame_done = o_done_r;

  `BAVG_NEVER(a_phase_two, clk, rst_n, phase_r && !(m_valid_r && m_two_r))
  `BAVG_NEXT(a_first_not_done, clk, rst_n, o_load && m_valid_r && !phase_r, !o_done_r)

endmodule

>>> rtl/core/box_average_3x3_stencil_top.sv
// ----------------------------------------------------------------------------
// Box average 3x3 stencil - top level
// One sweep of a 3x3 rounded mean over a column-major tile with halos.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : cell words, column-major, interior_columns+2 columns of
//            column_height cells, the two halo columns included.
//   out_ch : interior columns in order, one column behind the input; top
//            and bottom cell copied, the rest (sum of 3x3 + 4) / 9.
//            frame_done marks the final word of the tile.
//   cfg_*  : write-only registers; any write restarts the tile.
// The cell that completes a result word passes the stage-1 registers, the
//   work queue, the divide register and the output register.
// Throughput: one cell per cycle while in_ch.ready is high; the last cell
//   of each column from the third on gives two words, sent in turn.
// The line stores have one read and one write port and are not cleared;
//   only cells of the current tile ever reach a result.
// Reset clears positions and pipeline state and sets both registers to
//   1024. When the receiver stalls, a 4-entry queue, the divide register
//   and the output register absorb in-flight words, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module box_average_3x3_stencil_top #(
  parameter int MAX_HEIGHT  = bavg_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_COLUMNS = bavg_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bavg_cell_if.sink                       in_ch,
  bavg_result_if.source                   out_ch,
  input  logic                            cfg_we,
  input  logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bavg_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int COL_W = $clog2(MAX_COLUMNS + 2);

  localparam logic [ROW_W-1:0] HEIGHT_LAST_RST = ROW_W'(bavg_pkg::clamp_u(
    bavg_pkg::CFG_HEIGHT_RST, bavg_pkg::MIN_HEIGHT, MAX_HEIGHT) - 1);
  localparam logic [COL_W-1:0] COL_LAST_RST = COL_W'(bavg_pkg::clamp_u(
    bavg_pkg::CFG_COLUMNS_RST, bavg_pkg::MIN_COLUMNS, MAX_COLUMNS) + 1);

  logic [ROW_W-1:0]              height_last_r, height_last_nxt;
  logic [COL_W-1:0]              col_last_r, col_last_nxt;

  logic                          q_push, q_pop, q_nonempty;
  bavg_pkg::q_entry_t            q_data, q_head;
  logic [bavg_pkg::QCNT_W-1:0]   q_level;

  // last row index and last column index (halos included)
  assign height_last_nxt = ROW_W'(bavg_pkg::clamp_u(32'(cfg_wdata),
                                  bavg_pkg::MIN_HEIGHT, MAX_HEIGHT) - 1);
  assign col_last_nxt    = COL_W'(bavg_pkg::clamp_u(32'(cfg_wdata),
                                  bavg_pkg::MIN_COLUMNS, MAX_COLUMNS) + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_last_r <= HEIGHT_LAST_RST;
      col_last_r    <= COL_LAST_RST;
    end else if (cfg_we) begin
      unique case (bavg_pkg::cfg_reg_t'(cfg_index))
        bavg_pkg::REG_COLUMN_HEIGHT:    height_last_r <= height_last_nxt;
        bavg_pkg::REG_INTERIOR_COLUMNS: col_last_r    <= col_last_nxt;
      endcase
    end
  end

  bavg_front #(
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .restart     (cfg_we),
    .height_last (height_last_r),
    .col_last    (col_last_r),
    .q_level     (q_level),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  bavg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_nonempty),
    .level     (q_level)
  );

  bavg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_nonempty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> tb/sv/box_average_3x3_stencil_top_tb.sv
// ----------------------------------------------------------------------------
// Box average 3x3 stencil - self-checking testbench
// Feeds column-major tiles with halo columns through the cell channel under
// several register settings, and predicts every result word from its own copy
// of the three line stores. Each word taken from the result channel is
// checked against the oldest prediction. The sender works in bursts and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module box_average_3x3_stencil_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_H        = bavg_pkg::MAX_HEIGHT_DEF;
  localparam int MAX_C        = bavg_pkg::MAX_COLUMNS_DEF;
  localparam int SETTLE       = 10;    // margin for the pipeline to empty
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_CELLS = 900;
  localparam int TALL_CELLS   = 150;
  localparam int WIDE_CELLS   = 300;
  localparam int PRINT_CAP    = 40;

  typedef enum int {
    FILL_RANDOM,
    FILL_EXTREMES,
    FILL_NEAR_TOP,
    FILL_NEAR_ZERO
  } fill_t;

  typedef struct packed {
    logic [bavg_pkg::VALUE_W-1:0] new_value;
    logic                         frame_done;
  } result_word_t;

  // Tracks tile position and line stores, queues the words each cell gives.
  class box_mean_board;
    logic [bavg_pkg::VALUE_W-1:0] banks [3][MAX_H];
    logic [bavg_pkg::CFG_W-1:0]   height_reg;
    logic [bavg_pkg::CFG_W-1:0]   columns_reg;
    int                           row_pos;
    int                           col_pos;
    int                           bank_now;
    result_word_t                 due_words[$];
    int                           mismatches;

    function new();
      for (int b = 0; b < 3; b++)
        for (int i = 0; i < MAX_H; i++) banks[b][i] = '0;
      height_reg  = bavg_pkg::CFG_W'(bavg_pkg::CFG_HEIGHT_RST);
      columns_reg = bavg_pkg::CFG_W'(bavg_pkg::CFG_COLUMNS_RST);
      mismatches  = 0;
      restart();
    endfunction

    function void restart();
      row_pos  = 0;
      col_pos  = 0;
      bank_now = 0;
    endfunction

    function int eff_height();
      int h;
      h = int'(height_reg);
      if (h < bavg_pkg::MIN_HEIGHT) h = bavg_pkg::MIN_HEIGHT;
      else if (h > MAX_H) h = MAX_H;
      return h;
    endfunction

    function int eff_columns();
      int c;
      c = int'(columns_reg);
      if (c < bavg_pkg::MIN_COLUMNS) c = bavg_pkg::MIN_COLUMNS;
      else if (c > MAX_C) c = MAX_C;
      return c;
    endfunction

    function int tile_cells();
      return eff_height() * (eff_columns() + 2);
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void write_reg(bavg_pkg::cfg_reg_t idx, logic [bavg_pkg::CFG_W-1:0] value);
      if (idx == bavg_pkg::REG_COLUMN_HEIGHT) height_reg = value;
      else columns_reg = value;
      restart();
    endfunction

    function void take_cell(logic [bavg_pkg::VALUE_W-1:0] v);
      int           h, cols, r, k, cur, mid, old, t;
      int unsigned  acc;
      result_word_t w;
      h    = eff_height();
      cols = eff_columns() + 2;
      r    = row_pos;
      k    = col_pos;
      cur  = bank_now;
      mid  = (cur + 2) % 3;
      old  = (cur + 1) % 3;
      if (r >= h) r = 0;
      if (k >= cols) k = 0;
      banks[cur][r] = v;
      // row r of column k completes row r-1 of column k-1
      if (k >= 2 && r >= 1) begin
        t = r - 1;
        if (t == 0) begin
          w.new_value = banks[mid][0];
        end else begin
          acc = 4;
          for (int d = t - 1; d <= t + 1; d++)
            acc += banks[old][d] + banks[mid][d] + banks[cur][d];
          w.new_value = bavg_pkg::VALUE_W'(acc / 9);
        end
        w.frame_done = 1'b0;
        due_words.push_back(w);
        if (r == h - 1) begin
          w.new_value  = banks[mid][h-1];
          w.frame_done = (k == cols - 1);
          due_words.push_back(w);
        end
      end
      r++;
      if (r >= h) begin
        r = 0;
        k++;
        cur = (cur + 1) % 3;
        if (k >= cols) begin
          k   = 0;
          cur = 0;
        end
      end
      row_pos  = r;
      col_pos  = k;
      bank_now = cur;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task match_word(logic [bavg_pkg::VALUE_W-1:0] v, logic fd);
      result_word_t w;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("word %h/%b with nothing due", v, fd));
      end else begin
        w = due_words.pop_front();
        if (v !== w.new_value)
          report_mismatch($sformatf("new_value %h, expected %h", v, w.new_value));
        if (fd !== w.frame_done)
          report_mismatch($sformatf("frame_done %b, expected %b", fd, w.frame_done));
      end
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bavg_pkg::CFG_W-1:0]      cfg_wdata;

  bavg_cell_if   cell_ch ();
  bavg_result_if word_ch ();

  box_average_3x3_stencil_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cell_ch),
    .out_ch    (word_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  box_mean_board board = new();
  int            burst_left = 0;
  int            quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: alternating ready/stall runs, with occasional long clear stretches
  initial begin
    int run_left;
    int clear_left;
    bit level;
    run_left   = 0;
    clear_left = 0;
    level      = 1'b1;
    word_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (clear_left > 0) begin
        clear_left--;
        level = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        level = !level;
        run_left = level ? $urandom_range(0, 24) : $urandom_range(0, 11);
        if (level && $urandom_range(0, 9) == 0) clear_left = $urandom_range(50, 400);
      end
      word_ch.ready <= level;
    end
  end

  always @(posedge clk) begin
    if (rst_n && word_ch.valid && word_ch.ready)
      board.match_word(word_ch.new_value, word_ch.frame_done);
  end

  always @(posedge clk) begin
    if ((cell_ch.valid && cell_ch.ready) || (word_ch.valid && word_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: %0d cycles with no word moved, %0d words still due",
             QUIET_LIMIT, board.pending());
    $display("FAILURE");
    $finish;
  end

  function automatic logic [bavg_pkg::VALUE_W-1:0] pick_value(fill_t mode);
    case (mode)
      FILL_EXTREMES:  return ($urandom_range(0, 1) != 0) ? {bavg_pkg::VALUE_W{1'b1}} : '0;
      FILL_NEAR_TOP:  return {bavg_pkg::VALUE_W{1'b1}}
                             - bavg_pkg::VALUE_W'($urandom_range(0, 7));
      FILL_NEAR_ZERO: return bavg_pkg::VALUE_W'($urandom_range(0, 15));
      default:        return bavg_pkg::VALUE_W'($urandom());
    endcase
  endfunction

  function automatic fill_t pick_fill();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return FILL_RANDOM;
    if (roll == 7) return FILL_EXTREMES;
    if (roll == 8) return FILL_NEAR_TOP;
    return FILL_NEAR_ZERO;
  endfunction

  task automatic send_cell(input logic [bavg_pkg::VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 60);
      if (gap > 0) begin
        cell_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cell_ch.valid      <= 1'b1;
    cell_ch.cell_value <= v;
    @(posedge clk);
    while (!cell_ch.ready) @(posedge clk);
    board.take_cell(v);
  endtask

  task automatic send_cells(input int count, input fill_t mode);
    for (int i = 0; i < count; i++) send_cell(pick_value(mode));
  endtask

  // cells of halo columns give no word, so allow the pipeline to empty too
  task automatic wait_idle();
    cell_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(input bit set_h, input logic [bavg_pkg::CFG_W-1:0] h,
                              input bit set_c, input logic [bavg_pkg::CFG_W-1:0] c);
    if (set_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= bavg_pkg::REG_COLUMN_HEIGHT;
      cfg_wdata <= h;
      @(posedge clk);
      board.write_reg(bavg_pkg::REG_COLUMN_HEIGHT, h);
    end
    if (set_c) begin
      cfg_we    <= 1'b1;
      cfg_index <= bavg_pkg::REG_INTERIOR_COLUMNS;
      cfg_wdata <= c;
      @(posedge clk);
      board.write_reg(bavg_pkg::REG_INTERIOR_COLUMNS, c);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int                         sent;
    int                         size;
    int                         tiles;
    int                         which;
    int                         roll;
    logic [bavg_pkg::CFG_W-1:0] h;
    logic [bavg_pkg::CFG_W-1:0] c;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = bavg_pkg::REG_COLUMN_HEIGHT;
    cfg_wdata          = '0;
    cell_ch.valid      = 1'b0;
    cell_ch.cell_value = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset-size tile: only halo cells, then cut short by a register write
    send_cells(5, FILL_RANDOM);
    wait_idle();
    // below-range height and zero columns both act as the minimum tile
    program_regs(1'b1, bavg_pkg::CFG_W'(1), 1'b1, bavg_pkg::CFG_W'(0));
    send_cells(board.tile_cells(), FILL_NEAR_TOP);
    send_cells(board.tile_cells(), FILL_EXTREMES);
    wait_idle();

    sent = 0;
    while (sent < RANDOM_CELLS) begin
      wait_idle();
      roll = $urandom_range(0, 19);
      if (roll < 15) h = bavg_pkg::CFG_W'($urandom_range(3, 10));
      else if (roll < 18) h = bavg_pkg::CFG_W'($urandom_range(0, 2));
      else h = bavg_pkg::CFG_W'($urandom_range(11, 48));
      roll = $urandom_range(0, 9);
      if (roll < 7) c = bavg_pkg::CFG_W'($urandom_range(1, 6));
      else if (roll < 9) c = '0;
      else c = bavg_pkg::CFG_W'($urandom_range(7, 30));
      which = $urandom_range(0, 3);
      program_regs(which != 2, h, which != 1, c);
      tiles = $urandom_range(1, 3);
      for (int i = 0; i < tiles; i++) begin
        size = board.tile_cells();
        // broken tile: stopped part way, the next register write restarts it
        if ($urandom_range(0, 7) == 0) begin
          size = $urandom_range(1, size - 1);
          send_cells(size, pick_fill());
          sent += size;
          break;
        end
        send_cells(size, pick_fill());
        sent += size;
      end
    end

    // out-of-range values clamp: a tall tile of one interior column, then a
    // wide tile of three rows; only the start of each such tile is sent
    wait_idle();
    program_regs(1'b1, {bavg_pkg::CFG_W{1'b1}}, 1'b1, bavg_pkg::CFG_W'(0));
    send_cells(TALL_CELLS, FILL_RANDOM);
    wait_idle();
    program_regs(1'b1, bavg_pkg::CFG_W'(2), 1'b1, {bavg_pkg::CFG_W{1'b1}});
    send_cells(WIDE_CELLS, FILL_RANDOM);

    wait_idle();
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
